@@ hdl/gwmc_pkg.sv @@
`timescale 1ns / 1ps
package gwmc_pkg;

  localparam int GWMC_MAX_WIDTH = 256;

  localparam logic [23:0] TOTAL_MAX = 24'hFFFFFF;

  localparam logic [8:0] ROW_LENGTH_RESET     = 9'd140;
  localparam logic [7:0] PATTERN_FIRST_RESET  = 8'd88;
  localparam logic [7:0] PATTERN_SECOND_RESET = 8'd77;
  localparam logic [7:0] PATTERN_THIRD_RESET  = 8'd65;
  localparam logic [7:0] PATTERN_FOURTH_RESET = 8'd83;

  typedef enum logic [2:0] {
    REG_ROW_LENGTH,
    REG_PATTERN_FIRST,
    REG_PATTERN_SECOND,
    REG_PATTERN_THIRD,
    REG_PATTERN_FOURTH
  } gwmc_reg_t;

  typedef logic [23:0] gwmc_stack_t;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic [7:0] third;
    logic [7:0] fourth;
  } gwmc_pattern_t;

  typedef struct packed {
    logic [23:0] recent;
    gwmc_stack_t lm3;
    gwmc_stack_t lm2;
    gwmc_stack_t lm1;
    gwmc_stack_t ctr;
    gwmc_stack_t rp1;
    gwmc_stack_t rp2;
    gwmc_stack_t rp3;
    logic        left_ok;
    logic        right_ok;
    logic        full;
  } gwmc_view_t;

  typedef struct packed {
    logic [23:0] match_count;
    logic        count_saturated;
  } gwmc_result_t;

  function automatic logic [1:0] line_hits(input gwmc_pattern_t p, input logic [7:0] a0,
                                           input logic [7:0] a1, input logic [7:0] a2,
                                           input logic [7:0] a3);
    logic fwd;
    logic bwd;
    fwd = (a0 == p.first) && (a1 == p.second) && (a2 == p.third) && (a3 == p.fourth);
    bwd = (a0 == p.fourth) && (a1 == p.third) && (a2 == p.second) && (a3 == p.first);
    return {1'b0, fwd} + {1'b0, bwd};
  endfunction

endpackage

@@ hdl/gwmc_if.sv @@
`timescale 1ns / 1ps
interface gwmc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] grid_char;
  logic       last_char;

  modport source (output valid, output grid_char, output last_char, input ready);
  modport sink (input valid, input grid_char, input last_char, output ready);
endinterface

interface gwmc_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] match_count;
  logic        count_saturated;

  modport source (output valid, output match_count, output count_saturated, input ready);
  modport sink (input valid, input match_count, input count_saturated, output ready);
endinterface

@@ hdl/grid_word_match_counter_top.sv @@
`timescale 1ns / 1ps
// Counts a four-character word in a character grid, in all eight directions.
// Characters arrive on in_chan one request per cycle in row-major order; the
// request flagged last_char closes the grid. One request per cycle is taken
// for as long as the output side keeps up, set by the line buffer, which has
// one read port and reads the column stack four cells ahead of the cell at
// work. A request that closes the grid yields one result on out_chan in the
// next cycle when the output buffer is empty; other requests yield nothing.
// The result holds the saturated total and a flag that it reached its maximum;
// the total and the grid position are then cleared for the next grid.
// Results sit in a two-entry output buffer. While the receiver stalls, grid
// characters are still taken; in_chan.ready falls only when both entries hold
// results. Reset clears the position, the row count, the total and the output
// buffer, and restores the register defaults (row length 140, word XMAS). The
// line buffer is not cleared: it is refilled by the first three rows of a grid.
// User writes registers via cfg_we, cfg_index, cfg_data while idle; unenforced.
module grid_word_match_counter_top import gwmc_pkg::*; #(
  parameter int MAX_WIDTH = GWMC_MAX_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  gwmc_in_if.sink    in_chan,
  gwmc_out_if.source out_chan,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_data
);

  logic [8:0]    row_length_r;
  gwmc_pattern_t pattern_r;
  logic          take;
  logic          can_push;
  logic          res_push;
  gwmc_result_t  res;
  gwmc_result_t  out_data;
  gwmc_view_t    view;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r     <= ROW_LENGTH_RESET;
      pattern_r.first  <= PATTERN_FIRST_RESET;
      pattern_r.second <= PATTERN_SECOND_RESET;
      pattern_r.third  <= PATTERN_THIRD_RESET;
      pattern_r.fourth <= PATTERN_FOURTH_RESET;
    end else if (cfg_we) begin
      case (gwmc_reg_t'(cfg_index))
        REG_ROW_LENGTH:     row_length_r     <= cfg_data;
        REG_PATTERN_FIRST:  pattern_r.first  <= cfg_data[7:0];
        REG_PATTERN_SECOND: pattern_r.second <= cfg_data[7:0];
        REG_PATTERN_THIRD:  pattern_r.third  <= cfg_data[7:0];
        REG_PATTERN_FOURTH: pattern_r.fourth <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_chan.ready = can_push;
  assign take          = in_chan.valid && can_push;

  gwmc_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .ch         (in_chan.grid_char),
    .last       (in_chan.last_char),
    .row_length (row_length_r),
    .view       (view)
  );

  gwmc_matcher u_matcher (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .ch       (in_chan.grid_char),
    .last     (in_chan.last_char),
    .pattern  (pattern_r),
    .view     (view),
    .res_push (res_push),
    .res      (res)
  );

  gwmc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (out_chan.valid),
    .out_data  (out_data),
    .out_ready (out_chan.ready)
  );

  assign out_chan.match_count     = out_data.match_count;
  assign out_chan.count_saturated = out_data.count_saturated;

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_chan.last_char |=> out_chan.valid)
    else $error("closing request gave no result");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> out_chan.valid && !out_chan.ready || out_chan.valid)
    else $error("input stalled with no result pending");

  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    !(take && in_chan.last_char) && !out_chan.valid |=> !out_chan.valid)
    else $error("result appeared without a closing request");

endmodule

@@ hdl/gwmc_line_buf.sv @@
`timescale 1ns / 1ps
module gwmc_line_buf import gwmc_pkg::*; #(
  parameter int MAX_WIDTH = GWMC_MAX_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] ch,
  input  logic       last,
  input  logic [8:0] row_length,
  output gwmc_view_t view
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = ($clog2(MAX_WIDTH + 1) > 9) ? $clog2(MAX_WIDTH + 1) : 9;
  localparam logic [LW:0] MAXW = (LW + 1)'(MAX_WIDTH);

  gwmc_stack_t mem [MAX_WIDTH];

  logic [CW-1:0] col_r, col_nxt;
  logic [1:0]    rows_r, rows_nxt;
  logic [23:0]   recent_r, recent_nxt;
  gwmc_stack_t   win_r [6];
  gwmc_stack_t   win_nxt [6];
  gwmc_stack_t   head_r [4];
  gwmc_stack_t   head_nxt [4];
  gwmc_stack_t   rd_r;

  logic [LW:0]   len_eff;
  logic [LW:0]   col_ext;
  logic [LW:0]   rd_sum;
  logic          row_end;
  logic          wrap;
  logic          rd_ok;
  gwmc_stack_t   new_stack;

  always_comb begin
    len_eff = (LW + 1)'(row_length);
    if (len_eff == '0) begin
      len_eff = (LW + 1)'(1);
    end else if (len_eff > MAXW) begin
      len_eff = MAXW;
    end
  end

  assign col_ext   = (LW + 1)'(col_r);
  assign row_end   = (col_ext + (LW + 1)'(1)) >= len_eff;
  assign wrap      = row_end || last;
  assign rd_sum    = col_ext + (LW + 1)'(4);
  assign rd_ok     = rd_sum < MAXW;
  assign new_stack = {win_r[3][15:0], ch};

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      head_nxt[k] = head_r[k];
      if (take && (col_r == CW'(k))) begin
        head_nxt[k] = new_stack;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      win_nxt[i] = win_r[i + 1];
    end
    win_nxt[5] = rd_r;
    if (wrap) begin
      win_nxt[3] = head_nxt[0];
      win_nxt[4] = head_nxt[1];
      win_nxt[5] = head_nxt[2];
    end
  end

  always_comb begin
    col_nxt    = col_r + CW'(1);
    rows_nxt   = rows_r;
    recent_nxt = {recent_r[15:0], ch};
    if (row_end) begin
      col_nxt    = '0;
      recent_nxt = '0;
      if (rows_r != 2'd3) begin
        rows_nxt = rows_r + 2'd1;
      end
    end
    if (last) begin
      col_nxt    = '0;
      recent_nxt = '0;
      rows_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      rows_r   <= '0;
      recent_r <= '0;
    end else if (take) begin
      col_r    <= col_nxt;
      rows_r   <= rows_nxt;
      recent_r <= recent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      win_r  <= win_nxt;
      head_r <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mem[col_r] <= new_stack;
      if (wrap) begin
        rd_r <= head_nxt[3];
      end else if (rd_ok) begin
        rd_r <= mem[rd_sum[CW-1:0]];
      end
    end
  end

  assign view.recent   = recent_r;
  assign view.lm3      = win_r[0];
  assign view.lm2      = win_r[1];
  assign view.lm1      = win_r[2];
  assign view.ctr      = win_r[3];
  assign view.rp1      = win_r[4];
  assign view.rp2      = win_r[5];
  assign view.rp3      = rd_r;
  assign view.left_ok  = col_r >= CW'(3);
  assign view.right_ok = (col_ext + (LW + 1)'(3)) < len_eff;
  assign view.full     = rows_r == 2'd3;

endmodule

@@ hdl/gwmc_matcher.sv @@
`timescale 1ns / 1ps
module gwmc_matcher import gwmc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  logic [7:0]    ch,
  input  logic          last,
  input  gwmc_pattern_t pattern,
  input  gwmc_view_t    view,
  output logic          res_push,
  output gwmc_result_t  res
);

  logic [23:0] total_r, total_nxt;
  logic [3:0]  hits;
  logic [24:0] sum;
  logic [23:0] capped;

  always_comb begin
    hits = '0;
    if (view.left_ok) begin
      hits = hits + 4'(line_hits(pattern, view.recent[23:16], view.recent[15:8],
                                 view.recent[7:0], ch));
    end
    if (view.full) begin
      hits = hits + 4'(line_hits(pattern, view.ctr[23:16], view.ctr[15:8],
                                 view.ctr[7:0], ch));
      if (view.left_ok) begin
        hits = hits + 4'(line_hits(pattern, view.lm3[23:16], view.lm2[15:8],
                                   view.lm1[7:0], ch));
      end
      if (view.right_ok) begin
        hits = hits + 4'(line_hits(pattern, view.rp3[23:16], view.rp2[15:8],
                                   view.rp1[7:0], ch));
      end
    end
  end

  assign sum       = {1'b0, total_r} + 25'(hits);
  assign capped    = sum[24] ? TOTAL_MAX : sum[23:0];
  assign total_nxt = last ? '0 : capped;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (take) begin
      total_r <= total_nxt;
    end
  end

  assign res_push            = take && last;
  assign res.match_count     = capped;
  assign res.count_saturated = capped == TOTAL_MAX;

endmodule

@@ hdl/gwmc_out_buf.sv @@
`timescale 1ns / 1ps
module gwmc_out_buf import gwmc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  gwmc_result_t push_data,
  output logic         can_push,
  output logic         out_valid,
  output gwmc_result_t out_data,
  input  logic         out_ready
);

  logic         head_valid_r, head_valid_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  gwmc_result_t head_r, head_nxt;
  gwmc_result_t skid_r, skid_nxt;
  logic         pop;

  assign pop = head_valid_r && out_ready;

  always_comb begin
    head_valid_nxt = head_valid_r;
    skid_valid_nxt = skid_valid_r;
    head_nxt       = head_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        head_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (head_valid_r && !pop) begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end else begin
        head_nxt       = push_data;
        head_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      head_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      head_valid_r <= head_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign can_push  = !skid_valid_r;
  assign out_valid = head_valid_r;
  assign out_data  = head_r;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import gwmc_pkg::*;

  localparam int unsigned CLOCK_LIMIT   = 20_000_000;
  localparam int unsigned SETTLE_CYCLES = 4;

  class match_tally_model;
    logic [23:0]   column_stack [GWMC_MAX_WIDTH];
    logic [8:0]    row_length;
    gwmc_pattern_t word;
    logic [23:0]   recent;
    int unsigned   col;
    int unsigned   rows_done;
    int unsigned   tally;
    gwmc_result_t  totals_due [$];
    int unsigned   totals_checked;
    int unsigned   mismatches;

    function new();
      row_length = ROW_LENGTH_RESET;
      word = {PATTERN_FIRST_RESET, PATTERN_SECOND_RESET, PATTERN_THIRD_RESET,
              PATTERN_FOURTH_RESET};
      recent = '0;
      col = 0;
      rows_done = 0;
      tally = 0;
      totals_checked = 0;
      mismatches = 0;
      foreach (column_stack[i]) column_stack[i] = '0;
    endfunction

    function void set_reg(gwmc_reg_t idx, logic [8:0] val);
      case (idx)
        REG_ROW_LENGTH:     row_length = val;
        REG_PATTERN_FIRST:  word.first = val[7:0];
        REG_PATTERN_SECOND: word.second = val[7:0];
        REG_PATTERN_THIRD:  word.third = val[7:0];
        REG_PATTERN_FOURTH: word.fourth = val[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned effective_length();
      if (row_length == 0) return 1;
      if (row_length > GWMC_MAX_WIDTH) return GWMC_MAX_WIDTH;
      return 32'(row_length);
    endfunction

    function int unsigned word_hits(logic [7:0] a0, logic [7:0] a1, logic [7:0] a2,
                                    logic [7:0] a3);
      int unsigned n;
      n = 0;
      if (a0 == word.first && a1 == word.second && a2 == word.third && a3 == word.fourth)
        n++;
      if (a0 == word.fourth && a1 == word.third && a2 == word.second && a3 == word.first)
        n++;
      return n;
    endfunction

    function void push_column(int unsigned c, logic [7:0] ch);
      if (c < GWMC_MAX_WIDTH) column_stack[c] = {column_stack[c][15:0], ch};
    endfunction

    function void take_char(logic [7:0] ch, logic last);
      int unsigned  len;
      int unsigned  c;
      int unsigned  hits;
      bit           full;
      gwmc_result_t r;
      len = effective_length();
      c = col;
      hits = 0;
      full = (rows_done >= 3);
      if (c >= 3) hits += word_hits(recent[23:16], recent[15:8], recent[7:0], ch);
      if (full) begin
        hits += word_hits(column_stack[c][23:16], column_stack[c][15:8],
                          column_stack[c][7:0], ch);
        if (c >= 3)
          hits += word_hits(column_stack[c-3][23:16], column_stack[c-2][15:8],
                            column_stack[c-1][7:0], ch);
        if (c + 3 < len)
          hits += word_hits(column_stack[c+3][23:16], column_stack[c+2][15:8],
                            column_stack[c+1][7:0], ch);
      end
      tally += hits;
      if (tally > TOTAL_MAX) tally = TOTAL_MAX;
      if (c >= 3) push_column(c - 3, recent[23:16]);
      if (c + 1 >= len) begin
        if (c >= 2) push_column(c - 2, recent[15:8]);
        if (c >= 1) push_column(c - 1, recent[7:0]);
        push_column(c, ch);
        recent = '0;
        col = 0;
        if (rows_done < 3) rows_done++;
      end else begin
        recent = {recent[15:0], ch};
        col = c + 1;
      end
      if (last) begin
        r.match_count = tally[23:0];
        r.count_saturated = (tally == TOTAL_MAX);
        totals_due.push_back(r);
        recent = '0;
        col = 0;
        rows_done = 0;
        tally = 0;
      end
    endfunction

    function void compare_total(logic [23:0] cnt, logic sat);
      gwmc_result_t want;
      totals_checked++;
      if (totals_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected total %0d (saturated %0b) with none outstanding", cnt, sat);
        return;
      end
      want = totals_due.pop_front();
      if (cnt !== want.match_count || sat !== want.count_saturated) begin
        mismatches++;
        if (mismatches <= 10)
          $display("total mismatch: expected count %0d saturated %0b, got count %0d saturated %0b",
                   want.match_count, want.count_saturated, cnt, sat);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [8:0] cfg_data;

  gwmc_in_if  in_chan ();
  gwmc_out_if out_chan ();

  match_tally_model board;
  int unsigned      send_idle_pct = 0;
  int unsigned      stall_pct = 0;
  bit               no_idle_burst = 1'b0;
  int unsigned      chars_sent = 0;
  int unsigned      grids_sent = 0;
  longint unsigned  cycles = 0;

  grid_word_match_counter_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CLOCK_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready)
        board.take_char(in_chan.grid_char, in_chan.last_char);
      if (out_chan.valid && out_chan.ready)
        board.compare_total(out_chan.match_count, out_chan.count_saturated);
    end
  end

  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_chan.ready <= no_idle_burst || ($urandom_range(99) >= stall_pct);
    end
  end

  // The request is held until the block takes it.
  task automatic send_char(logic [7:0] ch, logic last);
    while (!no_idle_burst && $urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.grid_char <= ch;
    in_chan.last_char <= last;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    chars_sent++;
    if (last) grids_sent++;
  endtask

  task automatic settle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (board.totals_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(gwmc_reg_t idx, logic [8:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  task automatic configure(logic [8:0] len, logic [7:0] a, logic [7:0] b, logic [7:0] c,
                           logic [7:0] d);
    logic spare;
    settle();
    spare = 1'($urandom_range(1));
    put_reg(REG_ROW_LENGTH, len);
    put_reg(REG_PATTERN_FIRST, {spare, a});
    put_reg(REG_PATTERN_SECOND, {~spare, b});
    put_reg(REG_PATTERN_THIRD, {spare, c});
    put_reg(REG_PATTERN_FOURTH, {~spare, d});
    cfg_we <= 1'b0;
  endtask

  task automatic configure_random(logic [8:0] len);
    logic [7:0] a, b, c, d;
    a = 8'($urandom_range(255));
    b = 8'($urandom_range(255));
    c = 8'($urandom_range(255));
    d = 8'($urandom_range(255));
    case ($urandom_range(4))
      1: begin
        c = b;
        d = a;
      end
      2: begin
        b = a;
        c = a;
        d = a;
      end
      3: begin
        a = "X";
        b = "M";
        c = "A";
        d = "S";
      end
      4: begin
        a = a[0] ? 8'hFF : 8'h00;
        b = b[0] ? 8'hFF : 8'h00;
        c = c[0] ? 8'hFF : 8'h00;
        d = d[0] ? 8'hFF : 8'h00;
      end
      default: ;
    endcase
    configure(len, a, b, c, d);
  endtask

  function automatic logic [8:0] pick_row_length();
    int unsigned r;
    logic [8:0]  len;
    r = $urandom_range(31);
    if (r == 0) begin
      case ($urandom_range(2))
        0:       len = 9'd256;
        1:       len = 9'd300;
        default: len = 9'd511;
      endcase
    end else if (r <= 3) begin
      len = 9'($urandom_range(3));
    end else begin
      len = 9'($urandom_range(10, 4));
    end
    return len;
  endfunction

  task automatic play_grid();
    int unsigned len;
    int unsigned rows;
    int unsigned tail;
    int unsigned n;
    bit          noisy;
    logic [7:0]  ch;
    len = board.effective_length();
    noisy = ($urandom_range(5) == 0);
    if (len > 16) rows = 4;
    else if (len <= 3) rows = $urandom_range(12, 3);
    else if ($urandom_range(9) < 2) rows = $urandom_range(2);
    else rows = $urandom_range(7, 3);
    tail = $urandom_range(1) ? $urandom_range(len - 1) : 0;
    n = rows * len + tail;
    if (n == 0) n = 1;
    for (int k = 0; k < n; k++) begin
      if (noisy || $urandom_range(9) == 0) begin
        ch = 8'($urandom_range(255));
      end else begin
        case ($urandom_range(3))
          0:       ch = board.word.first;
          1:       ch = board.word.second;
          2:       ch = board.word.third;
          default: ch = board.word.fourth;
        endcase
      end
      send_char(ch, k == n - 1);
    end
  endtask

  initial begin
    string       s;
    int unsigned start_chars;
    int unsigned start_grids;
    board = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_ROW_LENGTH;
    cfg_data = '0;
    in_chan.valid = 1'b0;
    in_chan.grid_char = '0;
    in_chan.last_char = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_char("X", 1'b1);
    configure(9'd4, "X", "M", "A", "S");
    s = "XMASMMMAAAAMSAMX";
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    configure(9'd0, 8'h00, 8'hFF, 8'hFF, 8'h00);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
          configure_random(9'd4);
        end
        1: begin
          send_idle_pct = 83;
          stall_pct = 0;
          configure_random(9'd511);
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 83;
          configure_random(pick_row_length());
        end
        default: begin
          send_idle_pct = 26;
          stall_pct = 26;
          configure_random(9'($urandom_range(3)));
        end
      endcase
      start_chars = chars_sent;
      start_grids = grids_sent;
      while (chars_sent - start_chars < 250 || grids_sent - start_grids < 8) begin
        if (grids_sent != start_grids && ($urandom_range(3) == 0 || board.row_length > 16))
          configure_random(pick_row_length());
        no_idle_burst = ($urandom_range(7) == 0);
        play_grid();
      end
      no_idle_burst = 1'b0;
    end

    send_idle_pct = 0;
    stall_pct = 0;
    settle();
    $display("run covered %0d grids and %0d characters, %0d totals compared,", grids_sent,
             chars_sent, board.totals_checked);
    $display("row lengths from 0 to 511, varied words, idle and stall mixes");
    if (board.mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("%0d mismatches in total", board.mismatches);
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
